// File: rtl/mexp_pkg.sv
// Package for the modular exponentiation block: sequencer states and field width.
`timescale 1ns / 1ps

package mexp_pkg;

  // Width of every external payload port.
  localparam int FIELD_W = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_SCAN,
    S_MUL,
    S_SQR,
    S_FINISH
  } state_t;

endpackage

// File: rtl/modular_exponentiation.sv
// Modular exponentiation by right-to-left square and multiply, bit-serial modular products.
`timescale 1ns / 1ps
//
// Usage
//   Input: drive base_value and exponent and raise start. The transfer happens at a
//   rising edge with start high and busy low. busy stays high until the result is out.
//   Output: power_result is valid for exactly one cycle, marked by done. The receiver
//   cannot stall, so the result must be taken in that cycle.
//   Config: modulus is written through modulus_valid / modulus_ready. modulus_ready is
//   high only while the block is idle and start is low. Only the low WIDTH bits are
//   kept. A modulus of 0 or 1 gives a result of 0.
//   Sequence: every modular product is an interleaved shift-add over the WIDTH bits of
//   one operand, one bit per cycle. The base is first reduced by one such pass; then
//   each exponent bit, LSB first, up to the highest set bit, gives a multiply if set
//   and then a square. A modulus below two gives done in the cycle after the transfer.
//   One exponentiation runs at a time.
//   Reset: rst is synchronous and active high. It returns the block to idle and sets
//   the modulus to 2.
module modular_exponentiation #(
  parameter int WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mexp_pkg::FIELD_W-1:0]  base_value,
  input  logic [mexp_pkg::FIELD_W-1:0]  exponent,
  output logic                          done,
  output logic [mexp_pkg::FIELD_W-1:0]  power_result,
  input  logic                          modulus_valid,
  output logic                          modulus_ready,
  input  logic [mexp_pkg::FIELD_W-1:0]  modulus
);
  import mexp_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] CNT_TOP = CW'(WIDTH - 1);

  state_t state, state_next;

  logic [WIDTH-1:0] modulus_reg;  // configured modulus
  logic [WIDTH-1:0] r;            // running result
  logic [WIDTH-1:0] base;         // current base power
  logic [WIDTH-1:0] e;            // exponent, consumed LSB first
  logic [WIDTH-1:0] acc;          // product accumulator, below the modulus during a product
  logic [WIDTH-1:0] a_sh;         // multiplier operand, scanned MSB first
  logic [WIDTH-1:0] b_op;         // multiplicand
  logic [CW-1:0]    cnt;          // bits left in the current product after this one

  logic             mod_small;
  logic             mul_last;
  logic [WIDTH+1:0] x_sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH+1:0] x_red;
  logic [WIDTH-1:0] acc_next;

  assign mod_small = (modulus_reg < WIDTH'(2));
  assign mul_last  = (cnt == '0);

  // One step of the product: acc = (2*acc + bit*b) mod m. The sum stays below 3m, so
  // one of three candidates is the reduced value.
  always_comb begin
    m1    = {2'b00, modulus_reg};
    m2    = {1'b0, modulus_reg, 1'b0};
    x_sum = {1'b0, acc, 1'b0} + (a_sh[WIDTH-1] ? {2'b00, b_op} : '0);
    if (x_sum >= m2) begin
      x_red = x_sum - m2;
    end else if (x_sum >= m1) begin
      x_red = x_sum - m1;
    end else begin
      x_red = x_sum;
    end
    acc_next = x_red[WIDTH-1:0];
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = mod_small ? S_FINISH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mul_last) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (e == '0) begin
          state_next = S_FINISH;
        end else if (e[0]) begin
          state_next = S_MUL;
        end else begin
          state_next = S_SQR;
        end
      end
      S_MUL: begin
        if (mul_last) state_next = S_SQR;
      end
      S_SQR: begin
        if (mul_last) state_next = S_SCAN;
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Output logic; no modulus write in the cycle a start is accepted
  always_comb begin
    busy          = 1'b1;
    modulus_ready = 1'b0;
    done          = 1'b0;
    case (state)
      S_IDLE: begin
        busy          = 1'b0;
        modulus_ready = !start;
      end
      S_FINISH: done = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign power_result = FIELD_W'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_reg <= WIDTH'(2);
    end else if (modulus_valid && modulus_ready) begin
      modulus_reg <= modulus[WIDTH-1:0];
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          e <= exponent[WIDTH-1:0];
          if (mod_small) begin
            r <= '0;
          end else begin
            // base mod m computed as base * 1 mod m
            r    <= WIDTH'(1);
            a_sh <= base_value[WIDTH-1:0];
            b_op <= WIDTH'(1);
            acc  <= '0;
            cnt  <= CNT_TOP;
          end
        end
      end
      S_REDUCE, S_MUL, S_SQR: begin
        if (mul_last && state == S_MUL) begin
          // multiply done: load the square of the base
          r    <= acc_next;
          a_sh <= base;
          b_op <= base;
          acc  <= '0;
          cnt  <= CNT_TOP;
        end else begin
          acc  <= acc_next;
          a_sh <= a_sh << 1;
          cnt  <= cnt - 1'b1;
          if (mul_last) begin
            case (state)
              S_REDUCE: base <= acc_next;
              S_SQR: begin
                base <= acc_next;
                e    <= e >> 1;
              end
              default: begin
                base <= base;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (e != '0) begin
          acc  <= '0;
          cnt  <= CNT_TOP;
          b_op <= base;
          a_sh <= e[0] ? r : base;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Assertions
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_REDUCE || state == S_MUL || state == S_SQR) |-> (acc < modulus_reg))
    else $error("accumulator not reduced below modulus");

  a_operand_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_SQR) |-> (b_op < modulus_reg))
    else $error("multiplicand not reduced below modulus");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((r < modulus_reg) || (mod_small && r == '0)))
    else $error("result out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

endmodule

// File: bench/tb_modular_exponentiation.sv
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module tb_modular_exponentiation;

  import mexp_pkg::*;

  localparam int W = FIELD_W;
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
  // Largest prime below 2^64; handy for Fermat checks.
  localparam logic [W-1:0] PRIME_TOP = 64'hFFFF_FFFF_FFFF_FFC5;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         busy;
  logic [W-1:0] base_value = '0;
  logic [W-1:0] exponent = '0;
  logic         done;
  logic [W-1:0] power_result;
  logic         modulus_valid = 1'b0;
  logic         modulus_ready;
  logic [W-1:0] modulus = '0;

  modular_exponentiation dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .base_value    (base_value),
    .exponent      (exponent),
    .done          (done),
    .power_result  (power_result),
    .modulus_valid (modulus_valid),
    .modulus_ready (modulus_ready),
    .modulus       (modulus)
  );

  // 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One pending exponentiation: operands kept for the error message.
  typedef struct {
    logic [W-1:0] base;
    logic [W-1:0] expo;
    logic [W-1:0] modv;
    logic [W-1:0] power;
  } power_job_t;

  power_job_t   pending_powers[$];
  logic [W-1:0] modulus_shadow = 64'd2;   // register value after reset
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           powers_checked = 0;
  int           modulus_writes = 0;

  // ---------------------------------------------------------------------------
  // Predictor. Exact modular products through a double-width product; the
  // block gets the same value with its bit-serial reducer.
  // ---------------------------------------------------------------------------
  function automatic logic [W-1:0] mul_mod(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    logic [2*W-1:0] prod;
    prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    return W'(prod % {{W{1'b0}}, m});
  endfunction

  function automatic logic [W-1:0] power_mod(logic [W-1:0] base, logic [W-1:0] expo,
                                             logic [W-1:0] m);
    logic [W-1:0] sq;
    logic [W-1:0] acc;
    // Moduli of 0 and 1 collapse everything to 0.
    if (m < 2)
      return '0;
    sq  = base % m;
    acc = W'(1);
    // Right to left: multiply on set bits, square every step.
    for (int i = 0; i < W; i++) begin
      if (expo[i])
        acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
    end
    return acc;
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. done is a one-cycle strobe; the receiver cannot stall, so
  // every strobe is a transfer. Signals are read right after the edge, which
  // gives their pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    power_job_t job;
    if (!rst && done === 1'b1) begin
      if (pending_powers.size() == 0) begin
        note_mismatch($sformatf("power_result %h with nothing pending", power_result));
      end else begin
        job = pending_powers.pop_front();
        powers_checked++;
        if (power_result !== job.power)
          note_mismatch($sformatf("%h^%h mod %h: power_result %h, expected %h",
                                  job.base, job.expo, job.modv, power_result, job.power));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Sends one base/exponent pair after an optional idle gap. Leaves start high
  // so a back-to-back item needs no extra edge; the caller lowers it.
  task automatic send_power(logic [W-1:0] base, logic [W-1:0] expo, int gap = 0);
    power_job_t job;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    base_value <= base;
    exponent   <= expo;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Transfer took place at this edge: start high, busy low.
    job.base  = base;
    job.expo  = expo;
    job.modv  = modulus_shadow;
    job.power = power_mod(base, expo, modulus_shadow);
    pending_powers.push_back(job);
    items_sent++;
  endtask

  task automatic drain_powers();
    start <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  // Register writes only with the block idle: drain first.
  task automatic write_modulus(logic [W-1:0] value);
    drain_powers();
    modulus_valid <= 1'b1;
    modulus       <= value;
    @(posedge clk);
    while (!modulus_ready) @(posedge clk);
    modulus_valid  <= 1'b0;
    modulus_shadow  = value;
    modulus_writes++;
  endtask

  function automatic logic [W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [W-1:0] pick_modulus();
    logic [W-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = W'($urandom_range(0, 1));      // degenerate
      1:       v = W'(2);
      2:       v = ALL_ONES;
      3:       v = W'($urandom_range(3, 1000));
      4:       v = PRIME_TOP;
      5:       v = rand_word() | {1'b1, {(W-1){1'b0}}};
      default: v = rand_word();
    endcase
    return v;
  endfunction

  function automatic logic [W-1:0] pick_base(logic [W-1:0] m);
    logic [W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = W'(1);
      2:       v = m - 1;
      3:       v = m;
      4:       v = (m > 1) ? rand_word() % m : rand_word();
      default: v = rand_word();
    endcase
    return v;
  endfunction

  // Exponent length spread evenly over 0..W bits keeps the average run near
  // half the worst case; one in eight is a full-width random word.
  function automatic logic [W-1:0] pick_exponent();
    int           nbits;
    logic [W-1:0] v;
    if ($urandom_range(0, 7) == 0)
      return rand_word();
    nbits = $urandom_range(0, W);
    if (nbits == 0)
      return '0;
    v = rand_word() & (ALL_ONES >> (W - nbits));
    v[nbits-1] = 1'b1;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Modulus left at its reset value of 2.
  task automatic test_reset_modulus();
    send_power('0, '0);
    send_power(ALL_ONES, ALL_ONES);
    send_power(64'd3, 64'd5);
    send_power(ALL_ONES, '0);
  endtask

  // Zero exponent gives 1 for any modulus of 2 or more.
  task automatic test_zero_exponent();
    write_modulus(rand_word() | 64'd2);
    send_power(rand_word(), '0);
    send_power('0, '0);
  endtask

  // Moduli 0 and 1 must give 0, no divide trap.
  task automatic test_degenerate_modulus();
    write_modulus('0);
    send_power(64'd5, 64'd7);
    send_power('0, '0);
    write_modulus(64'd1);
    send_power(ALL_ONES, ALL_ONES);
    send_power(64'd2, '0);
  endtask

  task automatic test_extremes();
    write_modulus(ALL_ONES);
    send_power(ALL_ONES, ALL_ONES);          // base reduces to 0
    send_power(ALL_ONES - 1, 64'h8000_0000_0000_0000);
    send_power('0, 64'd1);
    send_power(64'd1, ALL_ONES);
    write_modulus(PRIME_TOP);
    send_power(PRIME_TOP - 1, 64'd1);
    send_power(64'd2, PRIME_TOP - 1);        // Fermat: expect 1
    send_power(PRIME_TOP, 64'd5);            // base equal to modulus
    send_power(ALL_ONES, ALL_ONES);          // base above modulus
    write_modulus(64'h8000_0000_0000_0000);
    send_power(64'd3, ALL_ONES);
    write_modulus(64'd3);
    send_power(ALL_ONES, ALL_ONES);
  endtask

  // Random items; a new modulus every dozen items. sender_idle_pct is the
  // chance of a short idle gap before an item.
  task automatic test_random_phase(int count, int sender_idle_pct);
    int gap;
    for (int i = 0; i < count; i++) begin
      if (i % 12 == 0)
        write_modulus(pick_modulus());
      gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 8) : 0;
      send_power(pick_base(modulus_shadow), pick_exponent(), gap);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_modulus();
    test_zero_exponent();
    test_degenerate_modulus();
    test_extremes();
    test_random_phase(28, 23);
    test_random_phase(26, 49);   // sender idles more often
    test_random_phase(26, 0);    // no idling

    drain_powers();
    repeat (8) @(posedge clk);

    $display("Ran %0d exponentiations, %0d results checked, %0d modulus writes.",
             items_sent, powers_checked, modulus_writes);
    $display("Covered reset modulus, moduli 0/1, full-width extremes, random sizes.");
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Timeout at about 6x the worst case for ~100 items.
  initial begin
    #40_000_000;
    $display("Timeout with %0d results still pending", pending_powers.size());
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/mexp_pkg.sv
rtl/modular_exponentiation.sv
bench/tb_modular_exponentiation.sv
